/* rtl/u16pos_pkg.sv */
// shared constants and helpers for the utf-16 position to utf-8 offset block
// no dependencies
package u16pos_pkg;

  localparam int unsigned OFFSET_BITS_DEFAULT = 32;
  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned WORD_BITS = 32;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [2:0][7:0] pend_bytes_t;

  localparam cfg_index_t REG_TARGET_LINE   = 2'd0;
  localparam cfg_index_t REG_TARGET_COLUMN = 2'd1;

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  localparam logic [7:0] MASK_2 = 8'hE0;
  localparam logic [7:0] LEAD_2 = 8'hC0;
  localparam logic [7:0] MASK_3 = 8'hF0;
  localparam logic [7:0] LEAD_3 = 8'hE0;
  localparam logic [7:0] MASK_4 = 8'hF8;
  localparam logic [7:0] LEAD_4 = 8'hF0;

  // sequence length from a lead byte; anything that is not a lead counts alone
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    if (!b[7]) len = 3'd1;
    else if ((b & MASK_2) == LEAD_2) len = 3'd2;
    else if ((b & MASK_3) == LEAD_3) len = 3'd3;
    else if ((b & MASK_4) == LEAD_4) len = 3'd4;
    else len = 3'd1;
    return len;
  endfunction

  function automatic word_t sat_add(input word_t a, input logic [1:0] n);
    word_t sum;
    logic [WORD_BITS:0] wide;
    wide = {1'b0, a} + (WORD_BITS + 1)'(n);
    sum = wide[WORD_BITS] ? '1 : wide[WORD_BITS-1:0];
    return sum;
  endfunction

endpackage

/* rtl/utf16_position_to_utf8_offset.sv */
// utf-16 line/column to utf-8 byte offset, at most one text byte per item
// depends on u16pos_pkg
// result path: an accepted last item passes the input register, then the result register
// throughput: one item per cycle; only a last item takes a stall from a full result stage
// the per-byte decode and counters sit between the input register and the state registers
// reset: rst is synchronous, active high; clears counters, handshakes and both targets
// after each result the text state returns to its reset value for the next text
module utf16_position_to_utf8_offset #(
  parameter int unsigned OFFSET_BITS = u16pos_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                data_byte,
  input  logic                      has_byte,
  input  logic                      is_last,
  output logic                      out_valid,
  input  logic                      out_stall,
  output u16pos_pkg::word_t         byte_offset,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  u16pos_pkg::cfg_index_t    cfg_index,
  input  u16pos_pkg::word_t         cfg_data
);
  import u16pos_pkg::*;

  typedef logic [OFFSET_BITS-1:0] offset_t;

  // configuration
  word_t target_line;
  word_t target_column;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_has;
  logic       s1_last;

  // text state
  offset_t     bytes_seen,      bytes_seen_next;
  word_t       current_line,    current_line_next;
  word_t       unit_count,      unit_count_next;
  pend_bytes_t pending_bytes,   pending_bytes_next;
  logic [1:0]  pending_count,   pending_count_next;
  logic [2:0]  sequence_length, sequence_length_next;
  logic        after_carriage_return, after_carriage_return_next;
  logic        position_found,  position_found_next;
  offset_t     found_offset,    found_offset_next;

  // result register
  word_t out_offset;
  word_t result_next;

  logic fire;

  // re-decode the unfinished sequence at a line end and find the offset
  function automatic offset_t close_line(input word_t units_in, input word_t column,
                                         input logic [1:0] count, input pend_bytes_t pb,
                                         input offset_t line_end);
    word_t      units;
    logic [2:0] idx;
    logic [2:0] len;
    logic       done;
    offset_t    off;
    units = units_in;
    idx = 3'd0;
    len = 3'd0;
    done = 1'b0;
    off = line_end;
    for (int k = 0; k < 3; k++) begin
      if (!done && idx < {1'b0, count}) begin
        if (units >= column) begin
          off = line_end - offset_t'(count) + offset_t'(idx);
          done = 1'b1;
        end else begin
          len = lead_length(pb[idx[1:0]]);
          if (idx + len > {1'b0, count}) len = 3'd1;
          units = sat_add(units, 2'd1);
          idx = idx + len;
        end
      end
    end
    return off;
  endfunction

  assign fire      = s1_valid && !(s1_last && out_valid && out_stall);
  assign in_stall  = s1_valid && !fire;
  assign cfg_ready = 1'b1;
  assign byte_offset = out_offset;

  always_comb begin
    logic       in_target;
    logic [2:0] len;
    logic [1:0] units;
    offset_t    chosen;
    logic [63:0] res64;
    bytes_seen_next            = bytes_seen;
    current_line_next          = current_line;
    unit_count_next            = unit_count;
    pending_bytes_next         = pending_bytes;
    pending_count_next         = pending_count;
    sequence_length_next       = sequence_length;
    after_carriage_return_next = after_carriage_return;
    position_found_next        = position_found;
    found_offset_next          = found_offset;
    in_target = 1'b0;
    len = 3'd0;
    units = 2'd1;
    chosen = '0;
    res64 = '0;

    if (s1_has) begin
      if (s1_byte == CHAR_LF && after_carriage_return) begin
        // second half of a cr lf pair
        after_carriage_return_next = 1'b0;
      end else begin
        after_carriage_return_next = 1'b0;
        in_target = (current_line == target_line) && !position_found;
        if (in_target && pending_count == 2'd0 && unit_count >= target_column) begin
          found_offset_next   = bytes_seen;
          position_found_next = 1'b1;
          in_target = 1'b0;
        end
        if (s1_byte == CHAR_LF || s1_byte == CHAR_CR) begin
          if (in_target) begin
            found_offset_next = close_line(unit_count, target_column, pending_count,
                                           pending_bytes, bytes_seen);
            position_found_next = 1'b1;
          end
          current_line_next          = sat_add(current_line, 2'd1);
          unit_count_next            = '0;
          pending_count_next         = 2'd0;
          sequence_length_next       = 3'd0;
          after_carriage_return_next = (s1_byte == CHAR_CR);
        end else if (in_target) begin
          if (pending_count == 2'd0) begin
            len = lead_length(s1_byte);
            if (len == 3'd1) begin
              unit_count_next = sat_add(unit_count, 2'd1);
            end else begin
              pending_bytes_next[0] = s1_byte;
              pending_count_next    = 2'd1;
              sequence_length_next  = len;
            end
          end else if ({1'b0, pending_count} + 3'd1 >= sequence_length
                       || pending_count == 2'd3) begin
            // codepoint above 0xffff needs a surrogate pair
            if (sequence_length == 3'd4
                && (pending_bytes[0][2:0] != 3'd0 || pending_bytes[1][5:4] != 2'd0))
              units = 2'd2;
            unit_count_next      = sat_add(unit_count, units);
            pending_count_next   = 2'd0;
            sequence_length_next = 3'd0;
          end else begin
            pending_bytes_next[pending_count] = s1_byte;
            pending_count_next = pending_count + 2'd1;
          end
        end
      end
      if (bytes_seen != '1) bytes_seen_next = bytes_seen + offset_t'(1);
    end

    // end of text: close the target line if still open
    if (s1_last && current_line_next == target_line && !position_found_next) begin
      found_offset_next = close_line(unit_count_next, target_column, pending_count_next,
                                     pending_bytes_next, bytes_seen_next);
      position_found_next = 1'b1;
    end
    chosen = position_found_next ? found_offset_next : bytes_seen_next;
    res64 = 64'(chosen);
    result_next = (res64[63:32] != 32'd0) ? '1 : res64[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_line   <= '0;
      target_column <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TARGET_LINE:   target_line   <= cfg_data;
        REG_TARGET_COLUMN: target_column <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte <= data_byte;
      s1_has  <= has_byte;
      s1_last <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && s1_last)) begin
      bytes_seen            <= '0;
      current_line          <= '0;
      unit_count            <= '0;
      pending_bytes         <= '0;
      pending_count         <= 2'd0;
      sequence_length       <= 3'd0;
      after_carriage_return <= 1'b0;
      position_found        <= 1'b0;
      found_offset          <= '0;
    end else if (fire) begin
      bytes_seen            <= bytes_seen_next;
      current_line          <= current_line_next;
      unit_count            <= unit_count_next;
      pending_bytes         <= pending_bytes_next;
      pending_count         <= pending_count_next;
      sequence_length       <= sequence_length_next;
      after_carriage_return <= after_carriage_return_next;
      position_found        <= position_found_next;
      found_offset          <= found_offset_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1_last) out_offset <= result_next;
  end

endmodule
